[src/quant_dwconv_9tap_requant_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the depthwise convolution requantizer
// Shared shorthand for clocked implication checks with a reset disable.
// ---------------------------------------------------------------------------
`ifndef QUANT_DWCONV_9TAP_REQUANT_MACROS_SVH
`define QUANT_DWCONV_9TAP_REQUANT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QDW_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define QDW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[src/qdw_pkg.sv]
// ---------------------------------------------------------------------------
// Depthwise convolution requantizer package
// Widths, register index codes and shared structs of the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package qdw_pkg;

   // Tap geometry: eight taps in the low word plus one extra tap.
   localparam int NUM_CARRIED_TAPS = 9;
   localparam int BYTE_W           = 8;
   localparam int TAP_VEC_W        = NUM_CARRIED_TAPS * BYTE_W;

   // Arithmetic widths.
   localparam int PROD_W = 17;
   localparam int ACC_W  = 32;
   localparam int MUL_W  = 31;
   localparam int SHF_W  = 5;
   localparam int THR_W  = 30;
   localparam int CLP_W  = 9;
   localparam int CSR_W  = 31;
   localparam int IDX_W  = 3;

   // Rounding constant added to the Q31 product.
   localparam logic signed [63:0] ROUND_CONST = 64'sh0000_0000_4000_0000;

   // Register index codes.
   localparam logic [IDX_W-1:0] REG_KERNEL_ZP  = 3'd0;
   localparam logic [IDX_W-1:0] REG_MULT       = 3'd1;
   localparam logic [IDX_W-1:0] REG_SHIFT      = 3'd2;
   localparam logic [IDX_W-1:0] REG_REM_MASK   = 3'd3;
   localparam logic [IDX_W-1:0] REG_REM_THRESH = 3'd4;
   localparam logic [IDX_W-1:0] REG_CLAMP_LOW  = 3'd5;
   localparam logic [IDX_W-1:0] REG_CLAMP_HIGH = 3'd6;
   localparam logic [IDX_W-1:0] REG_OUT_ZP     = 3'd7;

   // Requantization settings handed to the back half of the pipeline.
   typedef struct packed {
      logic [MUL_W-1:0]        mult;
      logic [SHF_W-1:0]        shift;
      logic [MUL_W-1:0]        rem_mask;
      logic [THR_W-1:0]        rem_thresh;
      logic signed [CLP_W-1:0] clamp_low;
      logic signed [CLP_W-1:0] clamp_high;
      logic [BYTE_W-1:0]       out_zp;
   } rq_cfg_type;

   // Pipeline control shared by all stages.
   typedef struct packed {
      logic advance;
   } pipe_ctl_type;

endpackage

`default_nettype wire

[src/quant_dwconv_9tap_requant.sv]
// Each request passes through seven register stages that all advance together.
// Throughput: one request per cycle while no held result stalls the pipeline.
// A stall on a valid result holds every stage and stalls the request side.
// Reset clears all valid bits and loads the configuration registers with their default values.
// ---------------------------------------------------------------------------
// Depthwise convolution requantizer, top level
// Nine-tap uint8 multiply-accumulate with Q31 requantization to one byte.
// ---------------------------------------------------------------------------
`default_nettype none

module quant_dwconv_9tap_requant #(
   parameter int TAPS = 9
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [63:0]                      req_activ_taps_low,
   input  wire logic [qdw_pkg::BYTE_W-1:0]       req_activ_tap_last,
   input  wire logic [63:0]                      req_kern_taps_low,
   input  wire logic [qdw_pkg::BYTE_W-1:0]       req_kern_tap_last,
   input  wire logic signed [qdw_pkg::ACC_W-1:0] req_bias,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [qdw_pkg::BYTE_W-1:0]            rsp_out_pixel,
   input  wire logic                             csr_wr_en,
   input  wire logic [qdw_pkg::IDX_W-1:0]        csr_index,
   input  wire logic [qdw_pkg::CSR_W-1:0]        csr_wdata
);
   import qdw_pkg::*;

   pipe_ctl_type             ctl;
   rq_cfg_type               cfg;
   logic [BYTE_W-1:0]        kernel_zp_ff;
   logic [MUL_W-1:0]         mult_ff;
   logic [SHF_W-1:0]         shift_ff;
   logic [MUL_W-1:0]         rem_mask_ff;
   logic [THR_W-1:0]         rem_thresh_ff;
   logic signed [CLP_W-1:0]  clamp_low_ff;
   logic signed [CLP_W-1:0]  clamp_high_ff;
   logic [BYTE_W-1:0]        out_zp_ff;
   logic                     mac_valid;
   logic signed [ACC_W-1:0]  mac_acc;

   // The pipeline moves unless a finished result is held by the consumer.
   assign ctl.advance = !rsp_valid || !rsp_stall;
   assign req_stall   = !ctl.advance;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_zp_ff  <= '0;
         mult_ff       <= 31'h4000_0000;
         shift_ff      <= '0;
         rem_mask_ff   <= '0;
         rem_thresh_ff <= '0;
         clamp_low_ff  <= -9'sd255;
         clamp_high_ff <= 9'sd255;
         out_zp_ff     <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_KERNEL_ZP:  kernel_zp_ff  <= csr_wdata[BYTE_W-1:0];
            REG_MULT:       mult_ff       <= csr_wdata[MUL_W-1:0];
            REG_SHIFT:      shift_ff      <= csr_wdata[SHF_W-1:0];
            REG_REM_MASK:   rem_mask_ff   <= csr_wdata[MUL_W-1:0];
            REG_REM_THRESH: rem_thresh_ff <= csr_wdata[THR_W-1:0];
            REG_CLAMP_LOW:  clamp_low_ff  <= $signed(csr_wdata[CLP_W-1:0]);
            REG_CLAMP_HIGH: clamp_high_ff <= $signed(csr_wdata[CLP_W-1:0]);
            REG_OUT_ZP:     out_zp_ff     <= csr_wdata[BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Settings for the requantization stages.
   always_comb begin
      cfg.mult       = mult_ff;
      cfg.shift      = shift_ff;
      cfg.rem_mask   = rem_mask_ff;
      cfg.rem_thresh = rem_thresh_ff;
      cfg.clamp_low  = clamp_low_ff;
      cfg.clamp_high = clamp_high_ff;
      cfg.out_zp     = out_zp_ff;
   end

   // Front half: products, sum and bias.
   qdw_mac #(
      .TAPS (TAPS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .in_valid  (req_valid),
      .activ     ({req_activ_tap_last, req_activ_taps_low}),
      .kern      ({req_kern_tap_last, req_kern_taps_low}),
      .bias      (req_bias),
      .kernel_zp (kernel_zp_ff),
      .out_valid (mac_valid),
      .acc       (mac_acc)
   );

   // Back half: requantization and the result register.
   qdw_rq u_rq (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .in_valid  (mac_valid),
      .acc       (mac_acc),
      .cfg       (cfg),
      .out_valid (rsp_valid),
      .out_pixel (rsp_out_pixel)
   );

endmodule

`default_nettype wire

[src/qdw_mac.sv]
// ---------------------------------------------------------------------------
// Tap multiply-accumulate stages
// Three stages: per-tap products, product sum, bias add with 32-bit wrap.
// ---------------------------------------------------------------------------
`default_nettype none

module qdw_mac #(
   parameter int TAPS = 9
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire qdw_pkg::pipe_ctl_type          ctl,
   input  wire logic                           in_valid,
   input  wire logic [qdw_pkg::TAP_VEC_W-1:0]  activ,
   input  wire logic [qdw_pkg::TAP_VEC_W-1:0]  kern,
   input  wire logic signed [qdw_pkg::ACC_W-1:0] bias,
   input  wire logic [qdw_pkg::BYTE_W-1:0]     kernel_zp,
   output logic                                out_valid,
   output logic signed [qdw_pkg::ACC_W-1:0]    acc
);
   import qdw_pkg::*;

   // Only the carried taps can contribute.
   localparam int ACT_TAPS = (TAPS > NUM_CARRIED_TAPS) ? NUM_CARRIED_TAPS : TAPS;
   localparam int SUM_W    = PROD_W + $clog2(ACT_TAPS + 1);

   logic                    v1_ff, v2_ff, v3_ff;
   logic signed [PROD_W-1:0] prod_ff [ACT_TAPS];
   logic signed [PROD_W-1:0] prod_in [ACT_TAPS];
   logic signed [ACC_W-1:0] bias1_ff, bias2_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // Stage 1: activation times offset kernel byte for each tap.
   always_comb begin
      logic signed [CLP_W-1:0]  kd;
      logic signed [PROD_W-1:0] a_ext;
      logic signed [PROD_W-1:0] k_ext;
      for (int i = 0; i < ACT_TAPS; i++) begin
         kd       = $signed({1'b0, kern[i*BYTE_W +: BYTE_W]}) - $signed({1'b0, kernel_zp});
         a_ext    = PROD_W'($signed({1'b0, activ[i*BYTE_W +: BYTE_W]}));
         k_ext    = PROD_W'(kd);
         prod_in[i] = a_ext * k_ext;
      end
   end

   // Stage 2: sum of the tap products at narrow width.
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < ACT_TAPS; i++) begin
         sum_in = sum_in + SUM_W'(prod_ff[i]);
      end
   end

   // Stage 3: bias add, wrapping at 32 bits.
   assign acc_in = bias2_ff + ACC_W'(sum_ff);

   // Valid bits move with the data when the pipeline advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (ctl.advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Payload registers load only behind a valid request.
   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         if (in_valid) begin
            prod_ff  <= prod_in;
            bias1_ff <= bias;
         end
         if (v1_ff) begin
            sum_ff   <= sum_in;
            bias2_ff <= bias1_ff;
         end
         if (v2_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   assign out_valid = v3_ff;
   assign acc       = acc_ff;

endmodule

`default_nettype wire

[src/qdw_rq.sv]
// ---------------------------------------------------------------------------
// Requantization stages
// Q31 multiply, rounding, rounding right shift, clamp and zero point add.
// ---------------------------------------------------------------------------
`default_nettype none

module qdw_rq (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire qdw_pkg::pipe_ctl_type            ctl,
   input  wire logic                             in_valid,
   input  wire logic signed [qdw_pkg::ACC_W-1:0] acc,
   input  wire qdw_pkg::rq_cfg_type              cfg,
   output logic                                  out_valid,
   output logic [qdw_pkg::BYTE_W-1:0]            out_pixel
);
   import qdw_pkg::*;

   localparam int V_W = ACC_W + 1;

   logic                    v4_ff, v5_ff, v6_ff, v7_ff;
   logic signed [63:0]      prod_ff, prod_in;
   logic [ACC_W-1:0]        q_ff, q_in;
   logic signed [V_W-1:0]   val_ff, val_in;
   logic [BYTE_W-1:0]       pix_ff, pix_in;

   // Stage 4: signed accumulator times the unsigned Q31 multiplier.
   assign prod_in = 64'(acc) * 64'($signed({1'b0, cfg.mult}));

   // Stage 5: add one half and keep bits 62 to 31.
   always_comb begin
      logic signed [63:0] rnd;
      rnd  = prod_ff + ROUND_CONST;
      q_in = rnd[62:31];
   end

   // Stage 6: arithmetic shift, rounded up when the remainder beats the threshold.
   always_comb begin
      logic [MUL_W-1:0]      masked;
      logic signed [V_W-1:0] rem;
      logic signed [V_W-1:0] thr;
      logic signed [ACC_W-1:0] shifted;
      masked  = q_ff[MUL_W-1:0] & cfg.rem_mask;
      rem     = $signed({2'b00, masked}) - $signed({{ACC_W{1'b0}}, q_ff[ACC_W-1]});
      thr     = $signed({3'b000, cfg.rem_thresh});
      shifted = $signed(q_ff) >>> cfg.shift;
      val_in  = V_W'(shifted) + ((rem > thr) ? V_W'(1) : V_W'(0));
   end

   // Stage 7: lower bound first, then upper bound, then the zero point.
   always_comb begin
      logic signed [V_W-1:0] clamped;
      clamped = val_ff;
      if (clamped < V_W'(cfg.clamp_low)) begin
         clamped = V_W'(cfg.clamp_low);
      end
      if (clamped > V_W'(cfg.clamp_high)) begin
         clamped = V_W'(cfg.clamp_high);
      end
      pix_in = clamped[BYTE_W-1:0] + cfg.out_zp;
   end

   // Valid bits; the last one is the result register's valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (ctl.advance) begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         if (in_valid) begin
            prod_ff <= prod_in;
         end
         if (v4_ff) begin
            q_ff <= q_in;
         end
         if (v5_ff) begin
            val_ff <= val_in;
         end
         if (v6_ff) begin
            pix_ff <= pix_in;
         end
      end
   end

   assign out_valid = v7_ff;
   assign out_pixel = pix_ff;

endmodule

`default_nettype wire

[src/qdw_checker.sv]
// ---------------------------------------------------------------------------
// Depthwise convolution requantizer port checker
// Watches the top-level handshake ports and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "quant_dwconv_9tap_requant_macros.svh"

module qdw_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_pixel
);

   // Reset empties the pipeline, so no result follows it.
   `QDW_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // The request side stalls only behind a held result.
   `QDW_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // A held result stays valid.
   `QDW_ASSERT_NEXT(a_hold_valid, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A held result keeps its value.
   `QDW_ASSERT_NEXT(a_hold_data, clock, reset, rsp_valid && rsp_stall, $stable(rsp_out_pixel))

endmodule

bind quant_dwconv_9tap_requant qdw_checker u_qdw_checker (.*);

`default_nettype wire
